/* src/triangle_pixel_inside_test_defines.svh */
// ----------------------------------------------------------------------------
// Triangle pixel inside test: assertion macros
// Concurrent check helpers for the RTL that carries assertions.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_PIXEL_INSIDE_TEST_DEFINES_SVH
`define TRIANGLE_PIXEL_INSIDE_TEST_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TPIT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked always (reset included).
`define TPIT_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tpit_pkg.sv */
// ----------------------------------------------------------------------------
// Triangle pixel inside test: package
// Transaction types, datapath widths and coordinate helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tpit_pkg;

    // Coordinate bits used by the test (4 to 14); fields stay 10 bits wide.
    localparam int COORD_BITS = 10;
    localparam int FIELD_W    = 10;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int EDGE_W     = PROD_W + 1;
    localparam int SUM_W      = EDGE_W + 1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef logic        [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [EDGE_W-1:0]     t_edge;
    typedef logic signed [SUM_W-1:0]      t_sum;

    typedef struct packed {
        logic [FIELD_W-1:0] vert0_x;
        logic [FIELD_W-1:0] vert0_y;
        logic [FIELD_W-1:0] vert1_x;
        logic [FIELD_W-1:0] vert1_y;
        logic [FIELD_W-1:0] vert2_x;
        logic [FIELD_W-1:0] vert2_y;
        logic [7:0]         fill_red;
        logic [7:0]         fill_green;
        logic [7:0]         fill_blue;
        logic [FIELD_W-1:0] query_x;
        logic [FIELD_W-1:0] query_y;
    } t_tri_in;

    typedef struct packed {
        logic               write_enable;
        logic               degenerate;
        logic [FIELD_W-1:0] pixel_x;
        logic [FIELD_W-1:0] pixel_y;
        logic [31:0]        pixel_colour;
    } t_pix_out;

    // Triangle set up for the edge tests: vertex 0 is the apex after the swap,
    // a = v1 - v0, b = v2 - v0, c = p - v0, area is the positive cross a x b.
    typedef struct packed {
        logic               degen;
        t_edge              area;
        t_diff              ax;
        t_diff              ay;
        t_diff              bx;
        t_diff              by;
        t_diff              cx;
        t_diff              cy;
        logic [FIELD_W-1:0] pixel_x;
        logic [FIELD_W-1:0] pixel_y;
        logic [23:0]        rgb;
    } t_setup;

    function automatic t_coord crd(input logic [FIELD_W-1:0] v);
        return COORD_BITS'(v);
    endfunction

    function automatic t_diff sdiff(input t_coord a, input t_coord b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

endpackage

`default_nettype wire

/* src/tpit_area.sv */
// ----------------------------------------------------------------------------
// Triangle pixel inside test: area and setup stages
// Signed area, degenerate flag, winding swap and edge vectors (two stages).
// ----------------------------------------------------------------------------
`default_nettype none

module tpit_area (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire tpit_pkg::t_tri_in i_item,
    input  wire logic            i_ready,
    output logic                 o_setup_valid,
    output tpit_pkg::t_setup     o_setup
);
    import tpit_pkg::*;

    logic    rdy1;
    logic    rdy2;
    logic    r_v1;
    logic    r_v2;
    t_prod   r_m0;
    t_prod   r_m1;
    t_tri_in r_item;
    t_prod   n_m0;
    t_prod   n_m1;
    t_setup  r_setup;
    t_setup  n_setup;
    t_edge   area;
    logic    neg;
    t_coord  v0x, v0y, v1x, v1y, v2x, v2y, qx, qy;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_stall = !rdy1;

    // Stage 1: the two products of the area cross term.
    always_comb begin
        n_m0 = t_prod'(sdiff(crd(i_item.vert0_x), crd(i_item.vert2_x)))
             * t_prod'(sdiff(crd(i_item.vert1_y), crd(i_item.vert2_y)));
        n_m1 = t_prod'(sdiff(crd(i_item.vert1_x), crd(i_item.vert2_x)))
             * t_prod'(sdiff(crd(i_item.vert0_y), crd(i_item.vert2_y)));
    end

    // Stage 2: area sign picks the winding; swap vertices 0 and 1 when negative.
    always_comb begin
        area = t_edge'(r_m0) - t_edge'(r_m1);
        neg  = area[EDGE_W-1];
        v0x  = neg ? crd(r_item.vert1_x) : crd(r_item.vert0_x);
        v0y  = neg ? crd(r_item.vert1_y) : crd(r_item.vert0_y);
        v1x  = neg ? crd(r_item.vert0_x) : crd(r_item.vert1_x);
        v1y  = neg ? crd(r_item.vert0_y) : crd(r_item.vert1_y);
        v2x  = crd(r_item.vert2_x);
        v2y  = crd(r_item.vert2_y);
        qx   = crd(r_item.query_x);
        qy   = crd(r_item.query_y);

        n_setup.degen   = (area == '0);
        n_setup.area    = neg ? -area : area;
        n_setup.ax      = sdiff(v1x, v0x);
        n_setup.ay      = sdiff(v1y, v0y);
        n_setup.bx      = sdiff(v2x, v0x);
        n_setup.by      = sdiff(v2y, v0y);
        n_setup.cx      = sdiff(qx, v0x);
        n_setup.cy      = sdiff(qy, v0y);
        n_setup.pixel_x = FIELD_W'(qx);
        n_setup.pixel_y = FIELD_W'(qy);
        n_setup.rgb     = {r_item.fill_red, r_item.fill_green, r_item.fill_blue};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_m0   <= n_m0;
            r_m1   <= n_m1;
            r_item <= i_item;
        end
        if (rdy2) begin
            r_setup <= n_setup;
        end
    end

    assign o_setup_valid = r_v2;
    assign o_setup       = r_setup;

endmodule

`default_nettype wire

/* src/tpit_edge.sv */
// ----------------------------------------------------------------------------
// Triangle pixel inside test: edge test stages
// Edge cross products, barycentric sign tests and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tpit_edge (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_setup_valid,
    input  wire tpit_pkg::t_setup i_setup,
    output logic                 o_ready,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output tpit_pkg::t_pix_out   o_pix
);
    import tpit_pkg::*;

    logic     rdy3;
    logic     rdy4;
    logic     rdy5;
    logic     r_v3;
    logic     r_v4;
    logic     r_v5;
    t_setup   r_s3;
    t_setup   r_s4;
    t_prod    r_cb1, r_cb2, r_ac1, r_ac2;
    t_edge    r_u;
    t_edge    r_v;
    t_edge    n_u;
    t_edge    n_v;
    t_sum     sum_uv;
    logic     hit;
    t_pix_out r_pix;
    t_pix_out n_pix;

    assign rdy5    = !r_v5 || !i_stall;
    assign rdy4    = !r_v4 || rdy5;
    assign rdy3    = !r_v3 || rdy4;
    assign o_ready = rdy3;

    // u scaled by area is c x b; v scaled by area is a x c.
    always_comb begin
        n_u = t_edge'(r_cb1) - t_edge'(r_cb2);
        n_v = t_edge'(r_ac1) - t_edge'(r_ac2);
    end

    // Area is positive here unless degenerate, so compare the crosses directly.
    always_comb begin
        sum_uv = t_sum'(r_u) + t_sum'(r_v);
        hit    = !r_s4.degen && !r_u[EDGE_W-1] && !r_v[EDGE_W-1]
              && (sum_uv < t_sum'(r_s4.area));
        n_pix.write_enable = hit;
        n_pix.degenerate   = r_s4.degen;
        n_pix.pixel_x      = r_s4.pixel_x;
        n_pix.pixel_y      = r_s4.pixel_y;
        n_pix.pixel_colour = {ALPHA_OPAQUE, r_s4.rgb};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy3) begin
                r_v3 <= i_setup_valid;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (rdy5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3  <= i_setup;
            r_cb1 <= t_prod'(i_setup.cx) * t_prod'(i_setup.by);
            r_cb2 <= t_prod'(i_setup.cy) * t_prod'(i_setup.bx);
            r_ac1 <= t_prod'(i_setup.ax) * t_prod'(i_setup.cy);
            r_ac2 <= t_prod'(i_setup.ay) * t_prod'(i_setup.cx);
        end
        if (rdy4) begin
            r_s4 <= r_s3;
            r_u  <= n_u;
            r_v  <= n_v;
        end
        if (rdy5) begin
            r_pix <= n_pix;
        end
    end

    assign o_valid = r_v5;
    assign o_pix   = r_pix;

endmodule

`default_nettype wire

/* src/triangle_pixel_inside_test.sv */
// ----------------------------------------------------------------------------
// Triangle pixel inside test: top level
// Exact-integer barycentric inside test of one candidate pixel per transaction.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while o_stall is low and returns one result
// per transaction, in order. A result waits on the output while the output is
// stalled. The five register stages (area products, winding swap and setup,
// edge products, edge differences, compare and output register) lie between
// input and output; every multiplier is 11 by 11 bits. Each stage moves on
// when the one after it is empty or moving, so empty slots are squeezed out
// and input is taken while a result waits as long as the pipeline has room.
// A zero-area triangle reports degenerate and never writes.
`default_nettype none

`include "triangle_pixel_inside_test_defines.svh"

module triangle_pixel_inside_test (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire tpit_pkg::t_tri_in i_item,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output tpit_pkg::t_pix_out   o_pix
);
    import tpit_pkg::*;

    logic   setup_valid;
    t_setup setup;
    logic   edge_ready;

    tpit_area u_area (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_item        (i_item),
        .i_ready       (edge_ready),
        .o_setup_valid (setup_valid),
        .o_setup       (setup)
    );

    tpit_edge u_edge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_setup_valid (setup_valid),
        .i_setup       (setup),
        .o_ready       (edge_ready),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pix         (o_pix)
    );

    `TPIT_ASSERT_NOW(a_degen_no_write, i_clk, i_rst_n, o_valid && o_pix.degenerate, !o_pix.write_enable, "degenerate triangle wrote a pixel")
    `TPIT_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stalled while output side can move")
    `TPIT_ASSERT_NEXT(a_reset_clears_output, i_clk, !i_rst_n, !o_valid, "output valid right after reset")

endmodule

`default_nettype wire

/* verif/tpit_pixel_checker.sv */
// ----------------------------------------------------------------------------
// Triangle pixel inside test: pixel checker
// Watches both channels, predicts each pixel result from the accepted triangle
// transaction and compares it field by field with the block's output, in order.
// ----------------------------------------------------------------------------
module tpit_pixel_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    input  wire logic         i_in_stall,
    input  tpit_pkg::t_tri_in  i_in_item,
    input  wire logic         i_out_valid,
    input  wire logic         i_out_stall,
    input  tpit_pkg::t_pix_out i_out_pix,
    output int                o_mismatch_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tpit_pkg::*;

    localparam longint COORD_MASK = (64'sd1 <<< COORD_BITS) - 1;

    t_pix_out expected_pixels[$];

    // Exact barycentric test in 64-bit integers, denominator kept positive.
    function automatic t_pix_out raster_pixel(input t_tri_in tri_item);
        longint x0, y0, x1, y1, x2, y2, px, py, swap_tmp;
        longint area, ax, ay, bx, by, cx, cy;
        longint d11, d12, d22, d13, d23, den, un, vn;
        t_pix_out pix;
        x0 = longint'(tri_item.vert0_x) & COORD_MASK;
        y0 = longint'(tri_item.vert0_y) & COORD_MASK;
        x1 = longint'(tri_item.vert1_x) & COORD_MASK;
        y1 = longint'(tri_item.vert1_y) & COORD_MASK;
        x2 = longint'(tri_item.vert2_x) & COORD_MASK;
        y2 = longint'(tri_item.vert2_y) & COORD_MASK;
        px = longint'(tri_item.query_x) & COORD_MASK;
        py = longint'(tri_item.query_y) & COORD_MASK;

        area = (x0 - x2) * (y1 - y2) - (x1 - x2) * (y0 - y2);
        pix.degenerate   = (area == 0);
        pix.write_enable = 1'b0;
        if (area != 0) begin
            // negative winding: swap vertices 0 and 1 so the apex edges stay inclusive
            if (area < 0) begin
                swap_tmp = x0; x0 = x1; x1 = swap_tmp;
                swap_tmp = y0; y0 = y1; y1 = swap_tmp;
            end
            ax = x1 - x0;  ay = y1 - y0;
            bx = x2 - x0;  by = y2 - y0;
            cx = px - x0;  cy = py - y0;
            d11 = ax * ax + ay * ay;
            d12 = ax * bx + ay * by;
            d22 = bx * bx + by * by;
            d13 = ax * cx + ay * cy;
            d23 = bx * cx + by * cy;
            den = d11 * d22 - d12 * d12;
            un  = d22 * d13 - d12 * d23;
            vn  = d11 * d23 - d12 * d13;
            pix.write_enable = (den > 0) && (un >= 0) && (vn >= 0) && (un + vn < den);
        end
        pix.pixel_x      = FIELD_W'(px);
        pix.pixel_y      = FIELD_W'(py);
        pix.pixel_colour = {ALPHA_OPAQUE, tri_item.fill_red, tri_item.fill_green,
                            tri_item.fill_blue};
        return pix;
    endfunction

    initial begin
        o_mismatch_count = 0;
        o_pending        = 0;
    end

    always @(posedge i_clk) begin
        t_pix_out want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                expected_pixels = {expected_pixels, raster_pixel(i_in_item)};
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel result with no transaction pending");
                    o_mismatch_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_out_pix.write_enable !== want.write_enable) begin
                        $error("write_enable: expected %0d, got %0d",
                               want.write_enable, i_out_pix.write_enable);
                        o_mismatch_count++;
                    end
                    if (i_out_pix.degenerate !== want.degenerate) begin
                        $error("degenerate: expected %0d, got %0d",
                               want.degenerate, i_out_pix.degenerate);
                        o_mismatch_count++;
                    end
                    if (i_out_pix.pixel_x !== want.pixel_x) begin
                        $error("pixel_x: expected %0d, got %0d",
                               want.pixel_x, i_out_pix.pixel_x);
                        o_mismatch_count++;
                    end
                    if (i_out_pix.pixel_y !== want.pixel_y) begin
                        $error("pixel_y: expected %0d, got %0d",
                               want.pixel_y, i_out_pix.pixel_y);
                        o_mismatch_count++;
                    end
                    if (i_out_pix.pixel_colour !== want.pixel_colour) begin
                        $error("pixel_colour: expected %08h, got %08h",
                               want.pixel_colour, i_out_pix.pixel_colour);
                        o_mismatch_count++;
                    end
                end
            end
            o_pending = expected_pixels.size();
        end
    end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// Triangle pixel inside test: testbench top
// Drives directed and random triangle/pixel transactions with random gaps and
// output stalls, including one long output hold-off; the pixel checker does
// the prediction and comparison, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tpit_pkg::*;

    localparam int COORD_MAX       = (1 << FIELD_W) - 1;
    localparam int RANDOM_ITEMS    = 1000;
    localparam int IDLE_PCT        = 15;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 20;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_tri_in   i_item;
    logic      o_valid;
    logic      i_stall;
    t_pix_out  o_pix;

    int        mismatch_count;
    int        pending_pixels;
    int        src_idle_pct = IDLE_PCT;
    int        snk_idle_pct = IDLE_PCT;
    logic      hold_off_req = 1'b0;
    t_tri_in   directed_items[$];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    triangle_pixel_inside_test uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_pix   (o_pix)
    );

    tpit_pixel_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_in_item        (i_item),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_out_pix        (o_pix),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_pixels)
    );

    function automatic t_tri_in tri_item_of(input int x0, y0, x1, y1, x2, y2,
                                            input int rgb, input int qx, qy);
        t_tri_in t;
        t.vert0_x    = FIELD_W'(x0);
        t.vert0_y    = FIELD_W'(y0);
        t.vert1_x    = FIELD_W'(x1);
        t.vert1_y    = FIELD_W'(y1);
        t.vert2_x    = FIELD_W'(x2);
        t.vert2_y    = FIELD_W'(y2);
        t.fill_red   = rgb[23:16];
        t.fill_green = rgb[15:8];
        t.fill_blue  = rgb[7:0];
        t.query_x    = FIELD_W'(qx);
        t.query_y    = FIELD_W'(qy);
        return t;
    endfunction

    // Queue one directed transaction.
    task automatic add_directed(input t_tri_in tri_item);
        directed_items = {directed_items, tri_item};
    endtask

    // Offer one transaction after random gaps; return at the edge that accepts it.
    task automatic drive_item(input t_tri_in tri_item);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= tri_item;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req <= 1'b0;
                for (int n = 0; n < HOLD_OFF_CYCLES; n++) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            i_stall <= (snk_idle_pct != 0) && ($urandom_range(0, 99) < snk_idle_pct);
        end
    end

    // Watchdog: too long without any transaction on either channel.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $error("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        t_tri_in    tri_item;
        logic [127:0] noise;
        int         mode, span, base_x, base_y, qx, qy;
        int         lo_x, hi_x, lo_y, hi_y;
        int         vx[3];
        int         vy[3];

        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_item  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero and full-scale degenerate triangles
        add_directed(tri_item_of(0, 0, 0, 0, 0, 0, 24'h000000, 0, 0));
        add_directed(tri_item_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                 COORD_MAX, COORD_MAX, 24'hFFFFFF,
                                 COORD_MAX, COORD_MAX));
        // full-screen triangle, positive winding: apex, far vertices, diagonal edge
        add_directed(tri_item_of(0, 0, COORD_MAX, 0, 0, COORD_MAX, 24'hFF0000, 0, 0));
        add_directed(tri_item_of(0, 0, COORD_MAX, 0, 0, COORD_MAX, 24'hFF0000,
                                 COORD_MAX, 0));
        add_directed(tri_item_of(0, 0, COORD_MAX, 0, 0, COORD_MAX, 24'hFF0000,
                                 0, COORD_MAX));
        add_directed(tri_item_of(0, 0, COORD_MAX, 0, 0, COORD_MAX, 24'hFF0000,
                                 COORD_MAX, COORD_MAX));
        add_directed(tri_item_of(0, 0, COORD_MAX, 0, 0, COORD_MAX, 24'hFF0000,
                                 511, 511));
        add_directed(tri_item_of(0, 0, COORD_MAX, 0, 0, COORD_MAX, 24'hFF0000,
                                 512, 511));
        // same triangle, negative winding: the swap moves the apex
        add_directed(tri_item_of(COORD_MAX, 0, 0, 0, 0, COORD_MAX, 24'h00FF00,
                                 COORD_MAX, 0));
        add_directed(tri_item_of(COORD_MAX, 0, 0, 0, 0, COORD_MAX, 24'h00FF00,
                                 0, 0));
        add_directed(tri_item_of(COORD_MAX, 0, 0, 0, 0, COORD_MAX, 24'h00FF00,
                                 100, 100));
        // collinear and repeated-vertex degenerates
        add_directed(tri_item_of(0, 0, 10, 10, 20, 20, 24'h0000FF, 10, 10));
        add_directed(tri_item_of(5, 7, 5, 7, 300, 40, 24'hA55A3C, 5, 7));
        // triangle in the far corner
        add_directed(tri_item_of(COORD_MAX, COORD_MAX, 0, COORD_MAX, COORD_MAX, 0,
                                 24'h123456, COORD_MAX, COORD_MAX));
        add_directed(tri_item_of(COORD_MAX, COORD_MAX, 0, COORD_MAX, COORD_MAX, 0,
                                 24'h123456, 0, 0));
        // small triangle: apex edges inclusive, opposite edge exclusive
        add_directed(tri_item_of(10, 10, 20, 10, 10, 20, 24'h808080, 15, 10));
        add_directed(tri_item_of(10, 10, 20, 10, 10, 20, 24'h808080, 10, 15));
        add_directed(tri_item_of(10, 10, 20, 10, 10, 20, 24'h808080, 15, 15));
        add_directed(tri_item_of(10, 10, 20, 10, 10, 20, 24'h808080, 9, 10));
        add_directed(tri_item_of(10, 10, 20, 10, 10, 20, 24'h808080, 12, 12));
        add_directed(tri_item_of(20, 10, 10, 10, 10, 20, 24'h7F7F7F, 15, 15));
        add_directed(tri_item_of(20, 10, 10, 10, 10, 20, 24'h7F7F7F, 20, 10));
        // long sliver
        add_directed(tri_item_of(0, 0, COORD_MAX, 1, COORD_MAX - 1, 0,
                                 24'h5AA5C3, 512, 0));

        foreach (directed_items[i]) drive_item(directed_items[i]);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            // a long stretch with no gaps or stalls in the middle of the run
            src_idle_pct = (k >= 350 && k < 700) ? 0 : IDLE_PCT;
            snk_idle_pct = src_idle_pct;
            if (k == 800) hold_off_req <= 1'b1;

            mode = $urandom_range(0, 99);
            if (mode < 90) begin
                // feeder-style scan: vertices near a base, query in the box or one beyond it
                span   = ($urandom_range(0, 9) == 0) ? COORD_MAX : $urandom_range(1, 24);
                base_x = $urandom_range(0, COORD_MAX);
                base_y = $urandom_range(0, COORD_MAX);
                for (int v = 0; v < 3; v++) begin
                    vx[v] = base_x + $urandom_range(0, span);
                    vy[v] = base_y + $urandom_range(0, span);
                    if (vx[v] > COORD_MAX) vx[v] = COORD_MAX;
                    if (vy[v] > COORD_MAX) vy[v] = COORD_MAX;
                end
                // collapse to a line now and then, by a repeated vertex or a shared y
                if (mode >= 78) begin
                    if (mode[0]) begin
                        vx[2] = vx[0];
                        vy[2] = vy[0];
                    end else begin
                        vy[1] = vy[0];
                        vy[2] = vy[0];
                    end
                end
                lo_x = COORD_MAX; hi_x = 0; lo_y = COORD_MAX; hi_y = 0;
                for (int v = 0; v < 3; v++) begin
                    if (vx[v] < lo_x) lo_x = vx[v];
                    if (vx[v] > hi_x) hi_x = vx[v];
                    if (vy[v] < lo_y) lo_y = vy[v];
                    if (vy[v] > hi_y) hi_y = vy[v];
                end
                qx = $urandom_range((lo_x > 0) ? lo_x - 1 : 0,
                                    (hi_x < COORD_MAX) ? hi_x + 1 : COORD_MAX);
                qy = $urandom_range((lo_y > 0) ? lo_y - 1 : 0,
                                    (hi_y < COORD_MAX) ? hi_y + 1 : COORD_MAX);
                tri_item = tri_item_of(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2],
                                       $urandom_range(0, 24'hFFFFFF), qx, qy);
            end else begin
                noise    = {$urandom, $urandom, $urandom, $urandom};
                tri_item = noise[$bits(t_tri_in)-1:0];
            end
            drive_item(tri_item);
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending_pixels != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_pixels == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
